// ===== rtl/rcpa_pkg.sv =====
// Shared types and constants for the refcounted page allocator.
// Used by every module of the block but rcpa_ram; depends on nothing.

package rcpa_pkg;

   // Pool geometry
   localparam int PAGES       = 1024;
   localparam int COUNT_WIDTH = 8;

   // Fixed field widths of the command and result beats
   localparam int CMD_W    = 2;
   localparam int PAGE_W   = 10;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 11;

   // Derived storage widths
   localparam int ADDR_W  = $clog2(PAGES);
   localparam int DEPTH_W = $clog2(PAGES + 1);

   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [DEPTH_W-1:0]     depth_type;
   typedef logic [COUNT_WIDTH-1:0] cnt_type;
   typedef logic [PAGE_W-1:0]      page_type;
   typedef logic [FREE_W-1:0]      free_type;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_REF = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COW     = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNREF = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      page_type         page;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      page_type            result_page;
      logic                copy_needed;
      free_type            free_pages;
   } rsp_type;

   // Control from the sequencer to the free stack
   typedef struct packed {
      logic     rd;
      logic     pop;
      logic     push;
      addr_type push_page;
   } stk_ctl_type;

   // Status from the free stack
   typedef struct packed {
      depth_type depth;
      addr_type  top_page;
      logic      empty;
      logic      full;
   } stk_sts_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COW2
   } state_type;

endpackage

// ===== rtl/rcpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.

module rcpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rcpa_free_stack.sv =====
// LIFO free-page stack: depth counter, low-water mark and stack RAM.
// Depends on rcpa_pkg and rcpa_ram.

module rcpa_free_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  rcpa_pkg::stk_ctl_type stk_ctl,
   output rcpa_pkg::stk_sts_type stk_sts
);

   rcpa_pkg::depth_type depth_ff, depth_in;
   rcpa_pkg::depth_type lowmark_ff, lowmark_in;
   rcpa_pkg::addr_type  rd_idx_ff, rd_idx_in;
   rcpa_pkg::addr_type  top_idx;
   rcpa_pkg::addr_type  ram_rd_data;
   logic                empty;
   logic                full;
   logic                wr_en;

   assign empty   = (depth_ff == '0);
   assign full    = (depth_ff == rcpa_pkg::depth_type'(rcpa_pkg::PAGES));
   assign top_idx = rcpa_pkg::addr_type'(depth_ff - rcpa_pkg::depth_type'(1));
   assign wr_en   = stk_ctl.push && !full;

   // Depth update; the low-water mark is the least depth seen since reset.
   // Entries below it were never pushed and still hold their own index.
   always_comb begin
      depth_in = depth_ff;
      if (stk_ctl.pop && !empty) begin
         depth_in = depth_ff - rcpa_pkg::depth_type'(1);
      end else if (wr_en) begin
         depth_in = depth_ff + rcpa_pkg::depth_type'(1);
      end
      lowmark_in = (depth_in < lowmark_ff) ? depth_in : lowmark_ff;
      rd_idx_in  = stk_ctl.rd ? top_idx : rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= rcpa_pkg::depth_type'(rcpa_pkg::PAGES);
         lowmark_ff <= rcpa_pkg::depth_type'(rcpa_pkg::PAGES);
      end else begin
         depth_ff   <= depth_in;
         lowmark_ff <= lowmark_in;
      end
      rd_idx_ff <= rd_idx_in;
   end

   rcpa_ram #(
      .WIDTH (rcpa_pkg::ADDR_W),
      .DEPTH (rcpa_pkg::PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rcpa_pkg::addr_type'(depth_ff)),
      .wr_data (stk_ctl.push_page),
      .rd_en   (stk_ctl.rd),
      .rd_addr (top_idx),
      .rd_data (ram_rd_data)
   );

   // Untouched entries read as their reset identity value
   always_comb begin
      stk_sts.depth    = depth_ff;
      stk_sts.empty    = empty;
      stk_sts.full     = full;
      stk_sts.top_page = (rcpa_pkg::depth_type'(rd_idx_ff) < lowmark_ff) ?
                         rd_idx_ff : ram_rd_data;
   end

endmodule

// ===== rtl/refcounted_page_allocator_core.sv =====
// Top level of the refcounted page allocator: command sequencer and count RAM.
// Depends on rcpa_pkg, rcpa_ram and rcpa_free_stack.

// After reset the block runs a clearing pass over the reference-count memory,
// one entry per cycle over all PAGES entries, with busy high. A command is
// taken when start is high and busy is low. Each command reads its count and
// the stack top in the accept cycle and updates them in the next, so busy is
// high during the update. A copy-on-write that hands out a fresh frame different
// from the original needs a second write to the count memory, which has a
// single write port. The result beat shows on rsp_data with rsp_strobe for
// exactly one cycle, from the result register loaded in the execute state;
// there is no way to hold it off, so capture it then.

module refcounted_page_allocator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rcpa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rcpa_pkg::rsp_type rsp_data
);

   rcpa_pkg::state_type   state_ff, state_in;
   rcpa_pkg::req_type     req_ff, req_in;
   rcpa_pkg::addr_type    clr_idx_ff, clr_idx_in;
   rcpa_pkg::cnt_type     cow_cnt_ff, cow_cnt_in;
   rcpa_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   rcpa_pkg::stk_ctl_type stk_ctl;
   rcpa_pkg::stk_sts_type stk_sts;

   logic                  cnt_wr_en;
   rcpa_pkg::addr_type    cnt_wr_addr;
   rcpa_pkg::cnt_type     cnt_wr_data;
   logic                  cnt_rd_en;
   rcpa_pkg::cnt_type     cnt_rd_data;

   logic                  accept;
   rcpa_pkg::addr_type    page_addr;
   logic                  page_ok;
   rcpa_pkg::cnt_type     cnt;
   logic                  cnt_zero;
   logic                  cnt_max;
   logic                  cnt_le1;
   logic                  cow_split;
   rcpa_pkg::depth_type   depth_after;

   assign accept = start && (state_ff == rcpa_pkg::ST_IDLE);

   // Decode of the command held in the execute cycle
   always_comb begin
      page_addr = rcpa_pkg::addr_type'(req_ff.page);
      page_ok   = int'(req_ff.page) < rcpa_pkg::PAGES;
      cnt       = page_ok ? cnt_rd_data : '0;
      cnt_zero  = (cnt == '0);
      cnt_max   = (cnt == '1);
      cnt_le1   = (cnt < rcpa_pkg::cnt_type'(2));
      cow_split = (req_ff.command == rcpa_pkg::CMD_COW) && !cnt_le1 &&
                  !stk_sts.empty && (stk_sts.top_page != page_addr);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcpa_pkg::ST_CLEAR: begin
            if (clr_idx_ff == rcpa_pkg::addr_type'(rcpa_pkg::PAGES - 1)) begin
               state_in = rcpa_pkg::ST_IDLE;
            end
         end
         rcpa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rcpa_pkg::ST_EXEC;
            end
         end
         rcpa_pkg::ST_EXEC: begin
            state_in = cow_split ? rcpa_pkg::ST_COW2 : rcpa_pkg::ST_IDLE;
         end
         rcpa_pkg::ST_COW2: begin
            state_in = rcpa_pkg::ST_IDLE;
         end
         default: begin
            state_in = rcpa_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs: memory accesses, stack control and the result beat
   always_comb begin
      req_in        = req_ff;
      clr_idx_in    = clr_idx_ff;
      cow_cnt_in    = cow_cnt_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = page_addr;
      cnt_wr_data   = '0;
      cnt_rd_en     = 1'b0;
      stk_ctl       = '0;
      depth_after   = stk_sts.depth;
      case (state_ff)
         rcpa_pkg::ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_idx_ff;
            clr_idx_in  = clr_idx_ff + rcpa_pkg::addr_type'(1);
         end
         rcpa_pkg::ST_IDLE: begin
            cnt_rd_en  = accept;
            stk_ctl.rd = accept && !stk_sts.empty;
            if (accept) begin
               req_in = req_data;
            end
         end
         rcpa_pkg::ST_EXEC: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.status      = rcpa_pkg::STAT_OK;
            rsp_in.result_page = '0;
            rsp_in.copy_needed = 1'b0;
            case (req_ff.command)
               rcpa_pkg::CMD_ALLOC: begin
                  if (stk_sts.empty) begin
                     rsp_in.status = rcpa_pkg::STAT_OOM;
                  end else begin
                     stk_ctl.pop        = 1'b1;
                     cnt_wr_en          = 1'b1;
                     cnt_wr_addr        = stk_sts.top_page;
                     cnt_wr_data        = rcpa_pkg::cnt_type'(1);
                     rsp_in.result_page = rcpa_pkg::page_type'(stk_sts.top_page);
                  end
               end
               rcpa_pkg::CMD_FREE: begin
                  if (cnt_zero) begin
                     rsp_in.status = rcpa_pkg::STAT_UNREF;
                  end else begin
                     cnt_wr_en          = 1'b1;
                     cnt_wr_data        = cnt - rcpa_pkg::cnt_type'(1);
                     stk_ctl.push       = (cnt == rcpa_pkg::cnt_type'(1));
                     stk_ctl.push_page  = page_addr;
                     rsp_in.result_page = req_ff.page;
                  end
               end
               rcpa_pkg::CMD_ADD_REF: begin
                  // saturates at the count maximum
                  cnt_wr_en          = page_ok && !cnt_max;
                  cnt_wr_data        = cnt + rcpa_pkg::cnt_type'(1);
                  rsp_in.result_page = req_ff.page;
               end
               rcpa_pkg::CMD_COW: begin
                  if (cnt_le1) begin
                     rsp_in.result_page = req_ff.page;
                  end else if (stk_sts.empty) begin
                     rsp_in.status = rcpa_pkg::STAT_OOM;
                  end else begin
                     stk_ctl.pop        = 1'b1;
                     rsp_in.copy_needed = 1'b1;
                     rsp_in.result_page = rcpa_pkg::page_type'(stk_sts.top_page);
                     cnt_wr_en          = 1'b1;
                     if (cow_split) begin
                        // fresh frame now; old frame's decrement next cycle
                        cnt_wr_addr = stk_sts.top_page;
                        cnt_wr_data = rcpa_pkg::cnt_type'(1);
                        cow_cnt_in  = cnt - rcpa_pkg::cnt_type'(1);
                     end else begin
                        // fresh frame is the old one: set to 1, then less one
                        cnt_wr_data = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (stk_ctl.pop) begin
               depth_after = depth_after - rcpa_pkg::depth_type'(1);
            end
            if (stk_ctl.push && !stk_sts.full) begin
               depth_after = depth_after + rcpa_pkg::depth_type'(1);
            end
            rsp_in.free_pages = rcpa_pkg::free_type'(depth_after);
         end
         rcpa_pkg::ST_COW2: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = cow_cnt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rcpa_pkg::ST_CLEAR;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff     <= req_in;
      cow_cnt_ff <= cow_cnt_in;
      rsp_ff     <= rsp_in;
   end

   rcpa_ram #(
      .WIDTH (rcpa_pkg::COUNT_WIDTH),
      .DEPTH (rcpa_pkg::PAGES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (rcpa_pkg::addr_type'(req_data.page)),
      .rd_data (cnt_rd_data)
   );

   rcpa_free_stack u_free_stack (
      .clock   (clock),
      .reset   (reset),
      .stk_ctl (stk_ctl),
      .stk_sts (stk_sts)
   );

   assign busy       = (state_ff != rcpa_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/rcpa_checker.sv =====
// Port-level checks for the refcounted page allocator, bound to the top level.
// Depends on rcpa_pkg and refcounted_page_allocator_core.

module rcpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rcpa_pkg::rsp_type rsp_data
);

   // Every accepted command gets its result beat
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result beat missing after accepted command");

   // One result per command: strobes never come back to back
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(rsp_strobe))
      else $error("result strobe held for two cycles");

   // The block blocks further commands while one is in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting a command");

   // Failed commands return page zero and never ask for a copy
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != rcpa_pkg::STAT_OK) |->
         (rsp_data.result_page == '0) && !rsp_data.copy_needed)
      else $error("error result carries a page or a copy flag");

   // The free count never exceeds the pool size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (int'(rsp_data.free_pages) <= rcpa_pkg::PAGES))
      else $error("free page count beyond pool size");

endmodule

bind refcounted_page_allocator_core rcpa_checker u_rcpa_checker (.*);
